[hdl/rhc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared widths, types and codes for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

    // Channel bits taken from each sample
    localparam int PIXEL_BITS = 16;
    // Fixed field widths on the stream ports
    localparam int CHAN_BITS  = 16;
    localparam int SAT_BITS   = 16;
    localparam int HUE_BITS   = 9;
    localparam int IN_W       = ((3 * CHAN_BITS) + 7) / 8 * 8;
    localparam int OUT_W      = ((HUE_BITS + SAT_BITS + CHAN_BITS) + 7) / 8 * 8;
    localparam int OUT_PAD    = OUT_W - (HUE_BITS + SAT_BITS + CHAN_BITS);

    // One quotient bit per cell; the saturation quotient sets the count
    localparam int N_CELLS    = SAT_BITS;
    localparam int N_FRONT    = 2;
    localparam int N_STAGES   = N_FRONT + N_CELLS;
    // Dividend / divisor width, holds 2*delta*65535 + max
    localparam int DIV_W      = PIXEL_BITS + SAT_BITS + 1;

    // Register word index
    localparam logic CFG_GREY_THR = 1'b0;

    typedef logic [PIXEL_BITS-1:0] t_pix;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // Word handed from cell to cell
    typedef struct packed {
        logic [DIV_W-1:0]    sat_n;
        logic [DIV_W-1:0]    sat_d;
        logic [DIV_W-1:0]    hue_n;
        logic [DIV_W-1:0]    hue_d;
        logic [SAT_BITS-1:0] sat_q;
        logic [SAT_BITS-1:0] hue_q;
        t_pix                value;
    } t_div_word;

    // Load enables for the two front stages
    typedef struct packed {
        logic ld_a;
        logic ld_b;
    } t_front_ctl;

endpackage

[hdl/rhc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_front
// Two register stages: channel max/min and sector, then divider operands.
// ----------------------------------------------------------------------------
module rhc_front (
    input  logic                         i_clk,
    input  rhc_pkg::t_front_ctl          i_ctl,
    input  logic [rhc_pkg::IN_W-1:0]     i_pixel,
    input  logic [rhc_pkg::CHAN_BITS-1:0] i_grey_thr,
    output rhc_pkg::t_div_word           o_word
);
    import rhc_pkg::*;

    localparam int TW = PIXEL_BITS + 4;

    t_pix                  w_r, w_g, w_b, w_mx, w_mn, w_delta;
    logic [PIXEL_BITS:0]   w_diff;
    t_sector               w_sec;
    logic                  w_chroma;

    t_pix                  r_mx, r_delta;
    logic [PIXEL_BITS:0]   r_diff;
    t_sector               r_sec;
    logic                  r_chroma;

    logic signed [TW-1:0]  w_base, w_sum;
    logic [TW-1:0]         w_six_d;
    logic [TW-1:0]         w_adj;
    logic [DIV_W-1:0]      w_tw, w_dw, w_mw;
    t_div_word             n_word;
    t_div_word             r_word;

    // Stage A: max, min, sector and grey test
    always_comb begin
        w_r = i_pixel[PIXEL_BITS-1:0];
        w_g = i_pixel[CHAN_BITS +: PIXEL_BITS];
        w_b = i_pixel[2*CHAN_BITS +: PIXEL_BITS];
        w_mx = (w_r > w_g) ? w_r : w_g;
        w_mn = (w_r < w_g) ? w_r : w_g;
        if (w_b > w_mx) w_mx = w_b;
        if (w_b < w_mn) w_mn = w_b;
        w_delta = w_mx - w_mn;
        if (w_r == w_mx) begin
            w_sec  = SEC_RED;
            w_diff = {1'b0, w_g} - {1'b0, w_b};
        end else if (w_g == w_mx) begin
            w_sec  = SEC_GREEN;
            w_diff = {1'b0, w_b} - {1'b0, w_r};
        end else begin
            w_sec  = SEC_BLUE;
            w_diff = {1'b0, w_r} - {1'b0, w_g};
        end
        w_chroma = (CHAN_BITS'(w_mx) > i_grey_thr) && (CHAN_BITS'(w_delta) > i_grey_thr);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_a) begin
            r_mx     <= w_mx;
            r_delta  <= w_delta;
            r_diff   <= w_diff;
            r_sec    <= w_sec;
            r_chroma <= w_chroma;
        end
    end

    // Stage B: hue/60*delta as a non-negative numerator, rounding folded in
    always_comb begin
        case (r_sec)
            SEC_GREEN: w_base = signed'({3'b0, r_delta, 1'b0});
            SEC_BLUE:  w_base = signed'({2'b0, r_delta, 2'b0});
            default:   w_base = signed'({4'b0, r_delta});
        endcase
        if (r_sec == SEC_RED) w_base = '0;
        w_sum   = w_base + signed'({{3{r_diff[PIXEL_BITS]}}, r_diff});
        w_six_d = {2'b0, r_delta, 2'b0} + {3'b0, r_delta, 1'b0};
        w_adj   = w_sum[TW-1] ? (TW'(w_sum) + w_six_d) : TW'(w_sum);
        w_tw    = DIV_W'(w_adj);
        w_dw    = DIV_W'(r_delta);
        w_mw    = DIV_W'(r_mx);
        n_word.value = r_mx;
        n_word.sat_q = '0;
        n_word.hue_q = '0;
        if (r_chroma) begin
            // round(65535*delta/max) = (2*65535*delta + max) / (2*max)
            n_word.sat_n = (w_dw << (SAT_BITS + 1)) - (w_dw << 1) + w_mw;
            n_word.sat_d = w_mw << SAT_BITS;
            // round(60*t/delta) = (120*t + delta) / (2*delta)
            n_word.hue_n = (w_tw << 7) - (w_tw << 3) + w_dw;
            n_word.hue_d = w_dw << SAT_BITS;
        end else begin
            n_word.sat_n = '0;
            n_word.sat_d = DIV_W'(1) << SAT_BITS;
            n_word.hue_n = '0;
            n_word.hue_d = DIV_W'(1) << SAT_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_b) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

[hdl/rhc_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_div_cell
// One restoring division step for both the saturation and hue quotients.
// ----------------------------------------------------------------------------
module rhc_div_cell (
    input  logic               i_clk,
    input  logic               i_en,
    input  rhc_pkg::t_div_word i_word,
    output rhc_pkg::t_div_word o_word
);
    import rhc_pkg::*;

    logic      w_sat_ge, w_hue_ge;
    t_div_word n_word;
    t_div_word r_word;

    // Trial subtract, divisor walks one bit down per cell
    always_comb begin
        w_sat_ge = (i_word.sat_n >= i_word.sat_d);
        w_hue_ge = (i_word.hue_n >= i_word.hue_d);
        n_word.value = i_word.value;
        n_word.sat_n = w_sat_ge ? (i_word.sat_n - i_word.sat_d) : i_word.sat_n;
        n_word.hue_n = w_hue_ge ? (i_word.hue_n - i_word.hue_d) : i_word.hue_n;
        n_word.sat_d = i_word.sat_d >> 1;
        n_word.hue_d = i_word.hue_d >> 1;
        n_word.sat_q = {i_word.sat_q[SAT_BITS-2:0], w_sat_ge};
        n_word.hue_q = {i_word.hue_q[SAT_BITS-2:0], w_hue_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

[hdl/rgb_to_hsv_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Hexcone RGB to HSV conversion on a pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled: two front stages
// find max, min and the division operands, then a row of 16 cells each
// resolves one quotient bit of saturation and hue side by side. The last
// cell is the output register. A stalled output only holds back items that
// would collide; bubbles in the row are closed up, so input keeps flowing
// until every stage is full. The grey threshold must only be written while
// the pipeline is empty.
module rgb_to_hsv_converter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Pixel in
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rhc_pkg::IN_W-1:0]      s_tdata,  // red_in, green_in, blue_in
    // HSV out
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rhc_pkg::OUT_W-1:0]     m_tdata   // hue_deg, saturation, value_level, pad
);
    import rhc_pkg::*;

    logic [CHAN_BITS-1:0] r_grey_thr;
    logic [N_STAGES-1:0]  r_vld;
    logic [N_STAGES-1:0]  w_adv;
    t_front_ctl           w_fctl;
    t_div_word            w_word [N_CELLS+1];

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_GREY_THR) ? 32'(r_grey_thr) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grey_thr <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == CFG_GREY_THR)) begin
            r_grey_thr <= pwdata[CHAN_BITS-1:0];
        end
    end

    // Stage load enables: a stage loads when empty or when it hands on
    always_comb begin
        w_adv[N_STAGES-1] = !r_vld[N_STAGES-1] || m_tready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= s_tvalid;
            for (int k = 1; k < N_STAGES; k++) begin
                if (w_adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign s_tready    = w_adv[0];
    assign w_fctl.ld_a = w_adv[0];
    assign w_fctl.ld_b = w_adv[1];

    rhc_front u_front (
        .i_clk      (i_clk),
        .i_ctl      (w_fctl),
        .i_pixel    (s_tdata),
        .i_grey_thr (r_grey_thr),
        .o_word     (w_word[0])
    );

    // Row of division cells
    for (genvar c = 0; c < N_CELLS; c++) begin : g_cell
        rhc_div_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_adv[N_FRONT+c]),
            .i_word (w_word[c]),
            .o_word (w_word[c+1])
        );
    end

    assign m_tvalid = r_vld[N_STAGES-1];
    assign m_tdata  = {OUT_PAD'(0), CHAN_BITS'(w_word[N_CELLS].value),
                       w_word[N_CELLS].sat_q, w_word[N_CELLS].hue_q[HUE_BITS-1:0]};

    // Checks
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[HUE_BITS-1:0] <= HUE_BITS'(360)))
        else $error("hue above full turn");

    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (w_word[N_CELLS].sat_q == '0)) |-> (m_tdata[HUE_BITS-1:0] == '0))
        else $error("hue set on a grey pixel");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (&r_vld && !m_tready))
        else $error("input held back with room in the pipeline");

endmodule

[sim/rgb_to_hsv_converter_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_check
// Watches both pixel channels, predicts the HSV result of every accepted
// request and compares it field by field with what leaves the block.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_check (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [15:0]               i_grey_thr,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    input  logic [rhc_pkg::IN_W-1:0]  i_s_tdata,  // red_in, green_in, blue_in
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    input  logic [rhc_pkg::OUT_W-1:0] i_m_tdata,  // hue_deg, saturation, value_level
    output int                        o_fail_count,
    output int                        o_pending
);
    import rhc_pkg::*;

    typedef struct packed {
        logic [HUE_BITS-1:0]  hue;
        logic [SAT_BITS-1:0]  sat;
        logic [CHAN_BITS-1:0] val;
    } t_hsv;

    t_hsv hsv_queue[$];

    // Exact integer hexcone conversion
    function automatic t_hsv hexcone_hsv(logic [IN_W-1:0] px, logic [15:0] thr);
        longint r, g, b, mx, mn, dl, diff, off, n;
        t_hsv res;
        r  = px[15:0];
        g  = px[31:16];
        b  = px[47:32];
        mx = (r > g) ? r : g;
        mn = (r < g) ? r : g;
        if (b > mx) mx = b;
        if (b < mn) mn = b;
        dl = mx - mn;
        res.hue = '0;
        res.sat = '0;
        res.val = mx[15:0];
        if (mx > thr && dl > thr) begin
            res.sat = (2 * dl * 65535 + mx) / (2 * mx);
            if (r == mx) begin
                diff = g - b;
                off  = 0;
            end else if (g == mx) begin
                diff = b - r;
                off  = 2;
            end else begin
                diff = r - g;
                off  = 4;
            end
            n = 60 * off * dl + 60 * diff;
            if (n < 0) n += 360 * dl;
            res.hue = (2 * n + dl) / (2 * dl);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_hsv want;
        t_hsv got;
        int   errs;
        errs = 0;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                hsv_queue.push_back(hexcone_hsv(i_s_tdata, i_grey_thr));
            if (i_m_tvalid && i_m_tready) begin
                got.hue = i_m_tdata[HUE_BITS-1:0];
                got.sat = i_m_tdata[HUE_BITS +: SAT_BITS];
                got.val = i_m_tdata[HUE_BITS+SAT_BITS +: CHAN_BITS];
                if (hsv_queue.size() == 0) begin
                    $error("result with no request pending");
                    errs++;
                end else begin
                    want = hsv_queue.pop_front();
                    if (got.hue !== want.hue) begin
                        $error("hue_deg: expected %0d, actual %0d", want.hue, got.hue);
                        errs++;
                    end
                    if (got.sat !== want.sat) begin
                        $error("saturation: expected %0d, actual %0d", want.sat, got.sat);
                        errs++;
                    end
                    if (got.val !== want.val) begin
                        $error("value_level: expected %0d, actual %0d",
                               want.val, got.val);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= hsv_queue.size();
    end
endmodule

[sim/rgb_to_hsv_converter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_test
// Drives directed and random pixels through the converter over several grey
// thresholds, with random gaps and back pressure, and reports the verdict.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_test;
    import rhc_pkg::*;

    localparam int LATENCY = N_STAGES + 4;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel, penable, pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata, prdata;
    logic              pready;
    logic              s_tvalid, s_tready, m_tvalid, m_tready;
    logic [IN_W-1:0]   s_tdata;
    logic [OUT_W-1:0]  m_tdata;
    logic [15:0]       grey_thr;
    int                fail_count, pending;
    int                hold_off;
    bit                calm;

    rgb_to_hsv_converter i_dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .pready, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
    );

    rgb_to_hsv_converter_check i_check (
        .i_clk, .i_rst_n, .i_grey_thr(grey_thr),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        int gap;
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                m_tready <= 1'b0;
                repeat (hold_off) @(posedge i_clk);
                hold_off = 0;
            end
            if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 7);
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic write_grey_thr(logic [15:0] thr);
        paddr   <= {CFG_GREY_THR, 2'b00};
        pwdata  <= {16'h0, thr};
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        grey_thr = thr;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one pixel and hold it until accepted
    task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_chan();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 255));
            1:       return 16'hFFFF - 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_pixels(int count);
        logic [15:0] r, g, b;
        for (int k = 0; k < count; k++) begin
            r = rand_chan();
            g = rand_chan();
            b = rand_chan();
            // ties for the maximum exercise sector priority
            case ($urandom_range(0, 7))
                0: g = r;
                1: b = r;
                2: b = g;
                3: begin g = r; b = r; end
                default: ;
            endcase
            send_pixel(r, g, b);
        end
    endtask

    logic [15:0] thr_set[5] = '{16'd0, 16'd1, 16'd1000, 16'd32768, 16'hFFFF};

    initial begin
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_tvalid = 0; s_tdata = 0; grey_thr = 0; hold_off = 0; calm = 0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, each sector, grey and zero pixels, ties
        write_grey_thr(16'd0);
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000, 16'h0000);
        send_pixel(16'h0000, 16'hFFFF, 16'h0000);
        send_pixel(16'h0000, 16'h0000, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000, 16'h0001);
        send_pixel(16'hFFFF, 16'hFFFF, 16'h0000);
        send_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
        send_pixel(16'd1, 16'd0, 16'd0);
        send_pixel(16'd2, 16'd1, 16'd0);
        send_pixel(16'd3, 16'd0, 16'd2);
        send_pixel(16'd65534, 16'd0, 16'd65535);
        send_pixel(16'h5555, 16'hAAAA, 16'h1234);
        drain();
        write_grey_thr(16'd100);
        send_pixel(16'd100, 16'd0, 16'd0);
        send_pixel(16'd101, 16'd0, 16'd0);
        send_pixel(16'd200, 16'd100, 16'd100);
        send_pixel(16'd201, 16'd100, 16'd100);
        drain();

        // Random phases across thresholds
        foreach (thr_set[t]) begin
            write_grey_thr(thr_set[t]);
            random_pixels(180);
            drain();
        end
        write_grey_thr(16'($urandom));
        random_pixels(150);
        drain();
        write_grey_thr(16'd0);

        // Long receiver hold-off while the sender keeps offering
        hold_off = 60;
        random_pixels(100);
        // sender pauses until every result is back
        drain();
        random_pixels(200);

        // Last part: no idling on either side
        calm = 1;
        random_pixels(200);
        drain();

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
